// ===== rtl/ibt_pkg.sv =====
`default_nettype none

package ibt_pkg;

   // Default sizing of the table
   localparam int TABLE_CELLS_DEF = 64;
   localparam int HASH_COUNT_DEF  = 4;
   localparam int VALUE_BYTES_DEF = 8;
   localparam int COUNT_BITS_DEF  = 16;

   // Operation codes; the spare code behaves as a lookup
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   // Result status codes
   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_ABSENT = 2'd1;
   localparam logic [1:0] STAT_FOUND  = 2'd2;
   localparam logic [1:0] STAT_UNDET  = 2'd3;

   // Hash seeds, lengths and mixing constants
   localparam logic [31:0] CHECK_SEED = 32'd11;
   localparam logic [3:0]  KEY_BYTES  = 4'd8;
   localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2      = 32'h1b873593;
   localparam logic [31:0] MM_C3      = 32'h85ebca6b;
   localparam logic [31:0] MM_C4      = 32'hc2b2ae35;
   localparam logic [31:0] MM_ADD     = 32'he6546b64;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [63:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] value_out;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] seed;
      logic [63:0] data;
      logic [3:0]  len;
   } hash_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hash;
   } hash_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/ibt_hash.sv =====
`default_nettype none

module ibt_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  ibt_pkg::hash_req_type hreq,
   output ibt_pkg::hash_rsp_type hrsp
);

   typedef enum logic [5:0] {
      HS_IDLE = 6'b000001,
      HS_K1   = 6'b000010,
      HS_K2   = 6'b000100,
      HS_MIX  = 6'b001000,
      HS_F1   = 6'b010000,
      HS_F2   = 6'b100000
   } hstate_type;

   hstate_type  state_ff, state_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  len_ff, len_in;
   logic [1:0]  blk_ff, blk_in;
   logic        done_ff, done_in;

   logic [1:0]  nblk, blk_inc;
   logic [31:0] word, tail_mask, word_m;
   logic [31:0] hk, rot13, mixed, fin_a, fin0, fin1;
   logic [31:0] mul_a, mul_b, prod;
   logic        more;

   // Select the current 32-bit block and mask the tail bytes
   always_comb begin
      nblk    = len_ff[3:2];
      blk_inc = blk_ff + 2'd1;
      word    = blk_ff[0] ? data_ff[63:32] : data_ff[31:0];
      case (len_ff[1:0])
         2'd1:    tail_mask = 32'h000000ff;
         2'd2:    tail_mask = 32'h0000ffff;
         2'd3:    tail_mask = 32'h00ffffff;
         default: tail_mask = 32'hffffffff;
      endcase
      word_m = (blk_ff < nblk) ? word : (word & tail_mask);
      more   = (blk_inc < nblk) || ((blk_inc == nblk) && (len_ff[1:0] != 2'd0));
   end

   // Mixing and finalisation terms around the shared multiplier
   always_comb begin
      hk    = h_ff ^ k_ff;
      rot13 = {hk[18:0], hk[31:19]};
      mixed = (rot13 << 2) + rot13 + ibt_pkg::MM_ADD;
      fin_a = h_ff ^ {28'd0, len_ff};
      fin0  = fin_a ^ (fin_a >> 16);
      fin1  = h_ff ^ (h_ff >> 13);
   end

   // Shared 32x32 multiplier, low half of the product
   always_comb begin
      case (state_ff)
         HS_K2: begin
            mul_a = {k_ff[16:0], k_ff[31:17]};
            mul_b = ibt_pkg::MM_C2;
         end
         HS_F1: begin
            mul_a = fin0;
            mul_b = ibt_pkg::MM_C3;
         end
         HS_F2: begin
            mul_a = fin1;
            mul_b = ibt_pkg::MM_C4;
         end
         default: begin
            mul_a = word_m;
            mul_b = ibt_pkg::MM_C1;
         end
      endcase
      prod = mul_a * mul_b;
   end

   // Sequence the blocks, the tail and the finalisation
   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      k_in     = k_ff;
      data_in  = data_ff;
      len_in   = len_ff;
      blk_in   = blk_ff;
      done_in  = 1'b0;
      case (state_ff)
         HS_IDLE: begin
            if (hreq.start) begin
               h_in     = hreq.seed;
               data_in  = hreq.data;
               len_in   = hreq.len;
               blk_in   = 2'd0;
               state_in = (hreq.len != 4'd0) ? HS_K1 : HS_F1;
            end
         end
         HS_K1: begin
            k_in     = prod;
            state_in = HS_K2;
         end
         HS_K2: begin
            k_in     = prod;
            state_in = HS_MIX;
         end
         HS_MIX: begin
            h_in     = (blk_ff < nblk) ? mixed : hk;
            blk_in   = blk_inc;
            state_in = more ? HS_K1 : HS_F1;
         end
         HS_F1: begin
            h_in     = prod;
            state_in = HS_F2;
         end
         HS_F2: begin
            h_in     = prod;
            done_in  = 1'b1;
            state_in = HS_IDLE;
         end
         default: begin
            state_in = HS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      h_ff    <= h_in;
      k_ff    <= k_in;
      data_ff <= data_in;
      len_ff  <= len_in;
      blk_ff  <= blk_in;
   end

   assign hrsp.done = done_ff;
   assign hrsp.hash = h_ff ^ (h_ff >> 16);

endmodule

`default_nettype wire

// ===== rtl/invertible_bloom_table_engine.sv =====
// Operation: an insert or erase hashes the key and value checks, then for each of HASH_COUNT
// indices updates one cell; a lookup computes its HASH_COUNT indices and copies the table to a
// scratch store before probing, then each peel pass checks the cells of count +-1 and peels
// every pure cell out of the scratch copy, for up to TABLE_CELLS passes.
// Throughput: one item at a time; a new request is taken only in the idle state.
// Reset: synchronous; a clearing pass zeroes the table, and no item is taken until it ends.
`default_nettype none

module invertible_bloom_table_engine #(
   parameter int TABLE_CELLS = ibt_pkg::TABLE_CELLS_DEF,
   parameter int HASH_COUNT  = ibt_pkg::HASH_COUNT_DEF,
   parameter int VALUE_BYTES = ibt_pkg::VALUE_BYTES_DEF,
   parameter int COUNT_BITS  = ibt_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ibt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ibt_pkg::rsp_type rsp_payload
);

   localparam int AW      = $clog2(TABLE_CELLS);
   localparam int HW      = $clog2(HASH_COUNT);
   localparam int BUCKETS = ((TABLE_CELLS / HASH_COUNT) > 0) ? (TABLE_CELLS / HASH_COUNT) : 1;
   localparam int BL      = $clog2(BUCKETS);
   localparam int RW      = BL + 1;
   localparam int IW      = AW + 2;

   localparam logic [63:0]           VALUE_MASK = 64'hffffffffffffffff >> (64 - 8 * VALUE_BYTES);
   localparam logic [3:0]            VALUE_LEN  = 4'(VALUE_BYTES);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_ALL  = {COUNT_BITS{1'b1}};
   // Rounded-up reciprocal of the bucket count, exact for every 32-bit hash
   localparam logic [63:0]           RECIP      = ((64'd1 << (32 + BL)) + 64'(BUCKETS) - 64'd1) /
                                                  64'(BUCKETS);
   localparam logic [31:0]           RECIP_LO   = RECIP[31:0];
   localparam logic                  RECIP_HI   = RECIP[32];
   localparam logic [31:0]           BUCKET_W   = 32'(BUCKETS);
   localparam logic [IW-1:0]         BUCKET_MUL = IW'(BUCKETS);
   localparam logic [IW-1:0]         TABLE_VAL  = IW'(TABLE_CELLS);
   localparam logic [AW-1:0]         LAST_CELL  = AW'(TABLE_CELLS - 1);
   localparam logic [HW-1:0]         LAST_HASH  = HW'(HASH_COUNT - 1);

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [63:0]           ksum;
      logic [31:0]           kchk;
      logic [63:0]           vsum;
      logic [31:0]           vchk;
   } cell_type;

   typedef enum logic [24:0] {
      ST_CLEAR    = 25'h0000001,
      ST_IDLE     = 25'h0000002,
      ST_CK_GO    = 25'h0000004,
      ST_CK_W     = 25'h0000008,
      ST_CV_GO    = 25'h0000010,
      ST_CV_W     = 25'h0000020,
      ST_IX_GO    = 25'h0000040,
      ST_IX_W     = 25'h0000080,
      ST_MOD      = 25'h0000100,
      ST_IX_DONE  = 25'h0000200,
      ST_RMW_RD   = 25'h0000400,
      ST_RMW_WR   = 25'h0000800,
      ST_COPY     = 25'h0001000,
      ST_COPY_END = 25'h0002000,
      ST_PR_RD    = 25'h0004000,
      ST_PR_CHK   = 25'h0008000,
      ST_PK_GO    = 25'h0010000,
      ST_PK_W     = 25'h0020000,
      ST_PV_GO    = 25'h0040000,
      ST_PV_W     = 25'h0080000,
      ST_NPURE    = 25'h0100000,
      ST_SC_RD    = 25'h0200000,
      ST_SC_CHK   = 25'h0400000,
      ST_SC_NEXT  = 25'h0800000,
      ST_FINISH   = 25'h1000000
   } state_type;

   // Table and scratch memories
   cell_type cell_mem    [TABLE_CELLS];
   cell_type scratch_mem [TABLE_CELLS];
   cell_type cell_rdata_ff, scr_rdata_ff;
   logic [AW-1:0] cell_ra, cell_wa, scr_ra, scr_wa;
   logic          cell_we, scr_we;
   cell_type      cell_wd, scr_wd, upd, rmw_rd;

   // Sequencer state
   state_type             state_ff, state_in;
   logic [AW-1:0]         sweep_ff, sweep_in;
   logic                  copy_pend_ff, copy_pend_in;
   logic [AW-1:0]         copy_wa_ff, copy_wa_in;
   logic [63:0]           cur_key_ff, cur_key_in;
   logic [63:0]           cur_val_ff, cur_val_in;
   logic [63:0]           lkey_ff, lkey_in;
   logic [COUNT_BITS-1:0] delta_ff, delta_in;
   logic                  tgt_scr_ff, tgt_scr_in;
   logic                  rec_ff, rec_in;
   logic                  scan_ff, scan_in;
   logic                  erased_ff, erased_in;
   logic [31:0]           kchk_ff, kchk_in;
   logic [31:0]           vchk_ff, vchk_in;
   logic [HW-1:0]         hix_ff, hix_in;
   logic [AW-1:0]         cix_ff, cix_in;
   logic [AW-1:0]         pass_ff, pass_in;
   logic [31:0]           div_ff, div_in;
   logic [63:0]           qprod_ff, qprod_in;
   logic [31:0]           quot_ff, quot_in;
   logic [1:0]            phase_ff, phase_in;
   logic [AW-1:0]         idx_cur_ff, idx_cur_in;
   logic [AW-1:0]         idx_ff [HASH_COUNT];
   logic                  idx_we;
   cell_type              wk_ff, wk_in;
   logic [1:0]            res_stat_ff, res_stat_in;
   logic [63:0]           res_val_ff, res_val_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ibt_pkg::rsp_type      rsp_ff, rsp_in;

   ibt_pkg::hash_req_type hash_req;
   ibt_pkg::hash_rsp_type hash_rsp;

   logic [63:0]   qprod_nx;
   logic [64:0]   qsum;
   logic [31:0]   quot_nx, rem_full;
   logic [RW-1:0] rem_nx;
   logic [IW-1:0] cidx, cidx_r;
   logic [AW-1:0] idx_new;
   logic          rd_pm1, rd_empty;
   logic          req_xfer;

   ibt_hash u_hash (
      .clock (clock),
      .reset (reset),
      .hreq  (hash_req),
      .hrsp  (hash_rsp)
   );

   // Issue hash jobs from the launch states
   always_comb begin
      hash_req.start = 1'b0;
      hash_req.seed  = ibt_pkg::CHECK_SEED;
      hash_req.data  = cur_key_ff;
      hash_req.len   = ibt_pkg::KEY_BYTES;
      case (state_ff)
         ST_CK_GO: begin
            hash_req.start = 1'b1;
         end
         ST_CV_GO: begin
            hash_req.start = 1'b1;
            hash_req.data  = cur_val_ff;
            hash_req.len   = VALUE_LEN;
         end
         ST_IX_GO: begin
            hash_req.start = 1'b1;
            hash_req.seed  = 32'(hix_ff);
         end
         ST_PK_GO: begin
            hash_req.start = 1'b1;
            hash_req.data  = wk_ff.ksum;
         end
         ST_PV_GO: begin
            hash_req.start = 1'b1;
            hash_req.data  = wk_ff.vsum & VALUE_MASK;
            hash_req.len   = VALUE_LEN;
         end
         default: begin
            hash_req.start = 1'b0;
         end
      endcase
   end

   // Bucket remainder by reciprocal multiplication, and the cell index it gives
   always_comb begin
      qprod_nx = {32'd0, div_ff} * {32'd0, RECIP_LO};
      qsum     = {1'b0, qprod_ff} + (RECIP_HI ? {1'b0, div_ff, 32'd0} : 65'd0);
      quot_nx  = 32'(qsum >> (32 + BL));
      rem_full = div_ff - (quot_ff * BUCKET_W);
      rem_nx   = rem_full[RW-1:0];
      cidx     = (IW'(hix_ff) * BUCKET_MUL) + IW'(rem_nx);
      cidx_r   = (cidx >= TABLE_VAL) ? (cidx - TABLE_VAL) : cidx;
      idx_new  = cidx_r[AW-1:0];
   end

   // Read-modify-write of one cell
   always_comb begin
      rmw_rd     = tgt_scr_ff ? scr_rdata_ff : cell_rdata_ff;
      upd.count  = rmw_rd.count + delta_ff;
      upd.ksum   = rmw_rd.ksum ^ cur_key_ff;
      upd.kchk   = rmw_rd.kchk ^ kchk_ff;
      upd.vsum   = rmw_rd.vsum ^ cur_val_ff;
      upd.vchk   = rmw_rd.vchk ^ vchk_ff;
      rd_pm1     = (scr_rdata_ff.count == COUNT_ONE) || (scr_rdata_ff.count == COUNT_ALL);
      rd_empty   = (scr_rdata_ff.count == '0) && (scr_rdata_ff.ksum == 64'd0) &&
                   (scr_rdata_ff.kchk == 32'd0);
   end

   // Memory ports
   always_comb begin
      cell_ra = (state_ff == ST_COPY) ? sweep_ff : idx_cur_ff;
      case (state_ff)
         ST_PR_RD: scr_ra = idx_ff[hix_ff];
         ST_SC_RD: scr_ra = cix_ff;
         default:  scr_ra = idx_cur_ff;
      endcase
      cell_we = (state_ff == ST_CLEAR) || ((state_ff == ST_RMW_WR) && !tgt_scr_ff);
      cell_wa = (state_ff == ST_CLEAR) ? sweep_ff : idx_cur_ff;
      cell_wd = (state_ff == ST_CLEAR) ? cell_type'('0) : upd;
      scr_we  = copy_pend_ff || ((state_ff == ST_RMW_WR) && tgt_scr_ff);
      scr_wa  = copy_pend_ff ? copy_wa_ff : idx_cur_ff;
      scr_wd  = copy_pend_ff ? cell_rdata_ff : upd;
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      cell_rdata_ff <= cell_mem[cell_ra];
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scratch_mem[scr_wa] <= scr_wd;
      end
      scr_rdata_ff <= scratch_mem[scr_ra];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // Main sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      copy_pend_in = 1'b0;
      copy_wa_in   = copy_wa_ff;
      cur_key_in   = cur_key_ff;
      cur_val_in   = cur_val_ff;
      lkey_in      = lkey_ff;
      delta_in     = delta_ff;
      tgt_scr_in   = tgt_scr_ff;
      rec_in       = rec_ff;
      scan_in      = scan_ff;
      erased_in    = erased_ff;
      kchk_in      = kchk_ff;
      vchk_in      = vchk_ff;
      hix_in       = hix_ff;
      cix_in       = cix_ff;
      pass_in      = pass_ff;
      div_in       = div_ff;
      qprod_in     = qprod_ff;
      quot_in      = quot_ff;
      phase_in     = phase_ff;
      idx_cur_in   = idx_cur_ff;
      idx_we       = 1'b0;
      wk_in        = wk_ff;
      res_stat_in  = res_stat_ff;
      res_val_in   = res_val_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               cur_key_in = req_payload.key;
               cur_val_in = req_payload.value_in & VALUE_MASK;
               lkey_in    = req_payload.key;
               tgt_scr_in = 1'b0;
               hix_in     = '0;
               case (req_payload.op)
                  ibt_pkg::OP_INSERT: begin
                     delta_in = COUNT_ONE;
                     rec_in   = 1'b0;
                     state_in = ST_CK_GO;
                  end
                  ibt_pkg::OP_ERASE: begin
                     delta_in = COUNT_ALL;
                     rec_in   = 1'b0;
                     state_in = ST_CK_GO;
                  end
                  default: begin
                     rec_in   = 1'b1;
                     state_in = ST_IX_GO;
                  end
               endcase
            end
         end
         ST_CK_GO: begin
            state_in = ST_CK_W;
         end
         ST_CK_W: begin
            if (hash_rsp.done) begin
               kchk_in  = hash_rsp.hash;
               state_in = ST_CV_GO;
            end
         end
         ST_CV_GO: begin
            state_in = ST_CV_W;
         end
         ST_CV_W: begin
            if (hash_rsp.done) begin
               vchk_in  = hash_rsp.hash;
               hix_in   = '0;
               state_in = ST_IX_GO;
            end
         end
         ST_IX_GO: begin
            state_in = ST_IX_W;
         end
         ST_IX_W: begin
            if (hash_rsp.done) begin
               div_in   = hash_rsp.hash;
               phase_in = 2'd0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // product, quotient, then remainder and index, one per cycle
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd0) begin
               qprod_in = qprod_nx;
            end else if (phase_ff == 2'd1) begin
               quot_in = quot_nx;
            end else begin
               idx_cur_in = idx_new;
               state_in   = ST_IX_DONE;
            end
         end
         ST_IX_DONE: begin
            if (rec_ff) begin
               idx_we = 1'b1;
               if (hix_ff == LAST_HASH) begin
                  sweep_in = '0;
                  state_in = ST_COPY;
               end else begin
                  hix_in   = hix_ff + HW'(1);
                  state_in = ST_IX_GO;
               end
            end else begin
               state_in = ST_RMW_RD;
            end
         end
         ST_RMW_RD: begin
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            if (hix_ff == LAST_HASH) begin
               if (tgt_scr_ff) begin
                  state_in = ST_SC_NEXT;
               end else begin
                  res_stat_in = ibt_pkg::STAT_DONE;
                  res_val_in  = 64'd0;
                  state_in    = ST_FINISH;
               end
            end else begin
               hix_in   = hix_ff + HW'(1);
               state_in = ST_IX_GO;
            end
         end
         ST_COPY: begin
            // stream the table into the scratch copy, each cell written in the cycle after its read
            sweep_in     = sweep_ff + AW'(1);
            copy_pend_in = 1'b1;
            copy_wa_in   = sweep_ff;
            if (sweep_ff == LAST_CELL) begin
               state_in = ST_COPY_END;
            end
         end
         ST_COPY_END: begin
            hix_in   = '0;
            pass_in  = '0;
            scan_in  = 1'b0;
            state_in = ST_PR_RD;
         end
         ST_PR_RD: begin
            state_in = ST_PR_CHK;
         end
         ST_PR_CHK: begin
            wk_in = scr_rdata_ff;
            if (rd_empty) begin
               res_stat_in = ibt_pkg::STAT_ABSENT;
               res_val_in  = 64'd0;
               state_in    = ST_FINISH;
            end else if (rd_pm1) begin
               state_in = ST_PK_GO;
            end else begin
               state_in = ST_NPURE;
            end
         end
         ST_PK_GO: begin
            state_in = ST_PK_W;
         end
         ST_PK_W: begin
            if (hash_rsp.done) begin
               state_in = (hash_rsp.hash == wk_ff.kchk) ? ST_PV_GO : ST_NPURE;
            end
         end
         ST_PV_GO: begin
            state_in = ST_PV_W;
         end
         ST_PV_W: begin
            if (hash_rsp.done) begin
               if (hash_rsp.hash != wk_ff.vchk) begin
                  state_in = ST_NPURE;
               end else if (wk_ff.ksum == lkey_ff) begin
                  res_stat_in = ibt_pkg::STAT_FOUND;
                  res_val_in  = wk_ff.vsum & VALUE_MASK;
                  state_in    = ST_FINISH;
               end else if (!scan_ff) begin
                  res_stat_in = ibt_pkg::STAT_ABSENT;
                  res_val_in  = 64'd0;
                  state_in    = ST_FINISH;
               end else begin
                  // peel this pure cell out of the scratch copy
                  erased_in  = 1'b1;
                  cur_key_in = wk_ff.ksum;
                  cur_val_in = wk_ff.vsum & VALUE_MASK;
                  kchk_in    = wk_ff.kchk;
                  vchk_in    = wk_ff.vchk;
                  delta_in   = (wk_ff.count == COUNT_ONE) ? COUNT_ALL : COUNT_ONE;
                  tgt_scr_in = 1'b1;
                  rec_in     = 1'b0;
                  hix_in     = '0;
                  state_in   = ST_IX_GO;
               end
            end
         end
         ST_NPURE: begin
            if (scan_ff) begin
               state_in = ST_SC_NEXT;
            end else if (hix_ff == LAST_HASH) begin
               scan_in   = 1'b1;
               cix_in    = '0;
               erased_in = 1'b0;
               state_in  = ST_SC_RD;
            end else begin
               hix_in   = hix_ff + HW'(1);
               state_in = ST_PR_RD;
            end
         end
         ST_SC_RD: begin
            state_in = ST_SC_CHK;
         end
         ST_SC_CHK: begin
            wk_in    = scr_rdata_ff;
            state_in = rd_pm1 ? ST_PK_GO : ST_SC_NEXT;
         end
         ST_SC_NEXT: begin
            if (cix_ff == LAST_CELL) begin
               if (!erased_ff || (pass_ff == LAST_CELL)) begin
                  res_stat_in = ibt_pkg::STAT_UNDET;
                  res_val_in  = 64'd0;
                  state_in    = ST_FINISH;
               end else begin
                  pass_in  = pass_ff + AW'(1);
                  hix_in   = '0;
                  scan_in  = 1'b0;
                  state_in = ST_PR_RD;
               end
            end else begin
               cix_in   = cix_ff + AW'(1);
               state_in = ST_SC_RD;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status    = res_stat_ff;
               rsp_in.value_out = res_val_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      copy_wa_ff  <= copy_wa_in;
      cur_key_ff  <= cur_key_in;
      cur_val_ff  <= cur_val_in;
      lkey_ff     <= lkey_in;
      delta_ff    <= delta_in;
      tgt_scr_ff  <= tgt_scr_in;
      rec_ff      <= rec_in;
      scan_ff     <= scan_in;
      erased_ff   <= erased_in;
      kchk_ff     <= kchk_in;
      vchk_ff     <= vchk_in;
      hix_ff      <= hix_in;
      cix_ff      <= cix_in;
      pass_ff     <= pass_in;
      div_ff      <= div_in;
      qprod_ff    <= qprod_in;
      quot_ff     <= quot_in;
      phase_ff    <= phase_in;
      idx_cur_ff  <= idx_cur_in;
      wk_ff       <= wk_in;
      res_stat_ff <= res_stat_in;
      res_val_ff  <= res_val_in;
      rsp_ff      <= rsp_in;
      if (idx_we) begin
         idx_ff[hix_ff] <= idx_cur_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_hash_done_waited: assert property (@(posedge clock) disable iff (reset)
      hash_rsp.done |-> (state_ff == ST_CK_W) || (state_ff == ST_CV_W) ||
                        (state_ff == ST_IX_W) || (state_ff == ST_PK_W) || (state_ff == ST_PV_W))
      else $error("hash result arrived with no job waiting");

   a_value_only_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != ibt_pkg::STAT_FOUND)) |->
         (rsp_payload.value_out == 64'd0))
      else $error("non-zero value on a result that is not found");

   a_one_store_write: assert property (@(posedge clock) disable iff (reset)
      !(cell_we && scr_we))
      else $error("table and scratch written in the same cycle");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE))
      else $error("sequencer idle right after an input transfer");
`endif

endmodule

`default_nettype wire

// ===== tb/table_checker.sv =====
`timescale 1ns / 100ps

module table_checker
   import ibt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending_count
);

   localparam int CELLS   = TABLE_CELLS_DEF;
   localparam int HASHES  = HASH_COUNT_DEF;
   localparam int BUCKETS = (CELLS / HASHES) > 0 ? CELLS / HASHES : 1;
   localparam int VBYTES  = VALUE_BYTES_DEF;
   localparam int CBITS   = COUNT_BITS_DEF;
   localparam logic [CBITS-1:0] COUNT_ONE  = 1;
   localparam logic [CBITS-1:0] COUNT_NEG  = '1;
   localparam logic [63:0]      VALUE_MASK = ~64'd0 >> (64 - 8 * VBYTES);
   // Index 0 is the live table, index 1 the peeling copy
   localparam int LIVE    = 0;
   localparam int SCRATCH = 1;

   logic [CBITS-1:0] cnt [2][CELLS];
   logic [63:0]      ksum[2][CELLS];
   logic [31:0]      kchk[2][CELLS];
   logic [63:0]      vsum[2][CELLS];
   logic [31:0]      vchk[2][CELLS];

   rsp_type expected_rsps[$];

   function automatic logic [31:0] mix_word(input logic [31:0] k);
      logic [31:0] t;
      t = k * MM_C1;
      t = {t[16:0], t[31:17]};
      return t * MM_C2;
   endfunction

   // Keyed 32-bit hash over the low len bytes, little-endian
   function automatic logic [31:0] murmur32(input logic [31:0] seed, input logic [63:0] data,
                                            input int len);
      logic [31:0] h;
      logic [31:0] k;
      int          b;
      h = seed;
      for (b = 0; b < len / 4; b++) begin
         k = data[32*b +: 32];
         h = h ^ mix_word(k);
         h = {h[18:0], h[31:19]};
         h = h * 32'd5 + MM_ADD;
      end
      if ((len & 3) != 0) begin
         k = 32'd0;
         for (int t = 0; t < (len & 3); t++) k[8*t +: 8] = data[8*(4*(len/4) + t) +: 8];
         h = h ^ mix_word(k);
      end
      h = h ^ 32'(len);
      h = h ^ (h >> 16);
      h = h * MM_C3;
      h = h ^ (h >> 13);
      h = h * MM_C4;
      h = h ^ (h >> 16);
      return h;
   endfunction

   function automatic int cell_index(input int i, input logic [63:0] key);
      logic [31:0] h;
      h = murmur32(32'(i), key, 8);
      return (i * BUCKETS + int'(h % BUCKETS)) % CELLS;
   endfunction

   function automatic void apply_update(input int t, input logic [CBITS-1:0] delta,
                                        input logic [63:0] key, input logic [63:0] val);
      logic [31:0] kh;
      logic [31:0] vh;
      int          c;
      val = val & VALUE_MASK;
      kh  = murmur32(CHECK_SEED, key, 8);
      vh  = murmur32(CHECK_SEED, val, VBYTES);
      for (int i = 0; i < HASHES; i++) begin
         c = cell_index(i, key);
         cnt[t][c]  = cnt[t][c] + delta;
         ksum[t][c] = ksum[t][c] ^ key;
         kchk[t][c] = kchk[t][c] ^ kh;
         vsum[t][c] = vsum[t][c] ^ val;
         vchk[t][c] = vchk[t][c] ^ vh;
      end
   endfunction

   function automatic bit is_pure(input int c);
      if (cnt[SCRATCH][c] != COUNT_ONE && cnt[SCRATCH][c] != COUNT_NEG) return 1'b0;
      return kchk[SCRATCH][c] == murmur32(CHECK_SEED, ksum[SCRATCH][c], 8) &&
             vchk[SCRATCH][c] == murmur32(CHECK_SEED, vsum[SCRATCH][c] & VALUE_MASK, VBYTES);
   endfunction

   // Probe the selected cells; STAT_DONE means no cell decided
   function automatic logic [1:0] probe_cells(input logic [63:0] key, output logic [63:0] val);
      int c;
      val = 64'd0;
      for (int i = 0; i < HASHES; i++) begin
         c = cell_index(i, key);
         if (cnt[SCRATCH][c] == 0 && ksum[SCRATCH][c] == 0 && kchk[SCRATCH][c] == 0)
            return STAT_ABSENT;
         if (is_pure(c)) begin
            if (ksum[SCRATCH][c] != key) return STAT_ABSENT;
            val = vsum[SCRATCH][c] & VALUE_MASK;
            return STAT_FOUND;
         end
      end
      return STAT_DONE;
   endfunction

   function automatic rsp_type lookup_key(input logic [63:0] key);
      rsp_type r;
      int      erased;
      r.status    = STAT_UNDET;
      r.value_out = 64'd0;
      for (int c = 0; c < CELLS; c++) begin
         cnt[SCRATCH][c]  = cnt[LIVE][c];
         ksum[SCRATCH][c] = ksum[LIVE][c];
         kchk[SCRATCH][c] = kchk[LIVE][c];
         vsum[SCRATCH][c] = vsum[LIVE][c];
         vchk[SCRATCH][c] = vchk[LIVE][c];
      end
      for (int pass = 0; pass < CELLS; pass++) begin
         r.status = probe_cells(key, r.value_out);
         if (r.status != STAT_DONE) return r;
         erased = 0;
         // Peel pure cells in index order; later cells see earlier removals
         for (int c = 0; c < CELLS; c++) begin
            if (!is_pure(c)) continue;
            if (ksum[SCRATCH][c] == key) begin
               r.status    = STAT_FOUND;
               r.value_out = vsum[SCRATCH][c] & VALUE_MASK;
               return r;
            end
            erased++;
            apply_update(SCRATCH, cnt[SCRATCH][c] == COUNT_ONE ? COUNT_NEG : COUNT_ONE,
                         ksum[SCRATCH][c], vsum[SCRATCH][c]);
         end
         if (erased == 0) break;
      end
      r.status    = STAT_UNDET;
      r.value_out = 64'd0;
      return r;
   endfunction

   function automatic rsp_type predict_result(input req_type q);
      rsp_type r;
      r.status    = STAT_DONE;
      r.value_out = 64'd0;
      case (q.op)
         OP_INSERT: apply_update(LIVE, COUNT_ONE, q.key, q.value_in);
         OP_ERASE:  apply_update(LIVE, COUNT_NEG, q.key, q.value_in);
         default:   r = lookup_key(q.key);
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      for (int t = 0; t < 2; t++)
         for (int c = 0; c < CELLS; c++) begin
            cnt[t][c]  = '0;
            ksum[t][c] = '0;
            kchk[t][c] = '0;
            vsum[t][c] = '0;
            vchk[t][c] = '0;
         end
   end

   assign pending_count = expected_rsps.size();

   // Predict on every request transfer, compare on every result transfer
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_rsps.push_back(predict_result(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", 64'd0, rsp_payload.value_out);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", 64'(want.status), 64'(rsp_payload.status));
               if (rsp_payload.value_out !== want.value_out)
                  report_mismatch("value_out", want.value_out, rsp_payload.value_out);
            end
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import ibt_pkg::*;

   localparam int  RANDOM_ITEMS = 800;
   localparam int  POOL_MAX     = 22;
   localparam int  DRAIN_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 30_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending_count;
   longint  cycle_count = 0;
   bit      quiet_mode = 1'b0;

   logic [63:0] pool_keys[$];
   logic [63:0] pool_vals[$];

   invertible_bloom_table_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   table_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int draw_gap();
      return quiet_mode ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Result side: stall for a drawn number of cycles, then take one transfer
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = draw_gap();
         rsp_stall = (n != 0);
         repeat (n) @(negedge clock);
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Drive one request and hold it until the transfer
   task automatic send_item(input logic [1:0] op, input logic [63:0] key,
                            input logic [63:0] val);
      int n;
      n = draw_gap();
      if (n != 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_payload.op       = op;
      req_payload.key      = key;
      req_payload.value_in = val;
      req_valid            = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_item();
      int pick;
      int idx;
      pick = $urandom_range(0, 99);
      if (pick < 35 && pool_keys.size() < POOL_MAX) begin
         pool_keys.push_back(rand64());
         pool_vals.push_back(rand64());
         send_item(OP_INSERT, pool_keys[$], pool_vals[$]);
      end else if (pick < 60 && pool_keys.size() > 0) begin
         idx = $urandom_range(0, pool_keys.size() - 1);
         send_item(OP_ERASE, pool_keys[idx], pool_vals[idx]);
         pool_keys.delete(idx);
         pool_vals.delete(idx);
      end else if (pick < 85 && pool_keys.size() > 0) begin
         idx = $urandom_range(0, pool_keys.size() - 1);
         send_item(OP_LOOKUP, pool_keys[idx], rand64());
      end else if (pick < 92) begin
         send_item(pick[0] ? OP_LOOKUP : OP_SPARE, rand64(), rand64());
      end else begin
         // Noise: stray erase or duplicate insert leaves the table inconsistent
         send_item(pick[0] ? OP_ERASE : OP_INSERT,
                   pool_keys.size() > 0 && pick[1] ? pool_keys[0] : rand64(), rand64());
      end
   endtask

   initial begin
      logic [63:0] k;
      logic [63:0] v;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, extremes, negative counts, duplicates
      send_item(OP_LOOKUP, 64'd0, 64'd0);
      send_item(OP_INSERT, 64'd0, 64'd0);
      send_item(OP_LOOKUP, 64'd0, '1);
      send_item(OP_INSERT, '1, '1);
      send_item(OP_LOOKUP, '1, 64'd0);
      send_item(OP_INSERT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_item(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      send_item(OP_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 64'd0);
      send_item(OP_LOOKUP, 64'h0123_4567_89ab_cdef, 64'd0);
      send_item(OP_ERASE, 64'd0, 64'd0);
      send_item(OP_LOOKUP, 64'd0, 64'd0);
      k = rand64();
      v = rand64();
      // Erase of a missing key wraps the counts below zero
      send_item(OP_ERASE, k, v);
      send_item(OP_LOOKUP, k, 64'd0);
      send_item(OP_SPARE, k, '1);
      send_item(OP_INSERT, k, v);
      // A key held twice never yields a pure cell of its own
      send_item(OP_INSERT, k, v);
      send_item(OP_INSERT, k, v);
      send_item(OP_LOOKUP, k, 64'd0);
      send_item(OP_ERASE, k, v);
      send_item(OP_ERASE, k, v);
      send_item(OP_ERASE, '1, '1);
      send_item(OP_ERASE, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_item(OP_ERASE, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      send_item(OP_LOOKUP, '1, 64'd0);

      // Random: mostly consistent inserts and erases of a live key set
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
         random_item();
      end
      req_valid = 1'b0;
      quiet_mode = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
